FILE: src/wfsf_pkg.sv
// wfsf_pkg: shared types and constants for the 802.11 station filter
// holds the frame record passed from parser to judge, verdict codes and field constants
// no dependencies
`default_nettype none

package wfsf_pkg;

    localparam int MAC_W       = 48;
    localparam int COUNT_W     = 5;
    localparam int VERDICT_W   = 3;
    localparam int PORT_W      = 3;
    localparam int CFG_INDEX_W = 3;

    typedef logic [MAC_W-1:0]     mac_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [VERDICT_W-1:0] verdict_t;
    typedef logic [PORT_W-1:0]    port_t;

    // byte count limits
    localparam count_t COUNT_MAX = 5'd31;
    localparam count_t HDR_LEN   = 5'd24;
    localparam count_t LLC_END   = 5'd28;

    // frame control type field
    localparam logic [7:0] FC_TYPE_MASK = 8'h0C;
    localparam logic [7:0] FC_TYPE_CTRL = 8'h04;

    // individual/group bit of the first address byte
    localparam int GROUP_BIT = 40;

    // ds bit codes
    localparam logic [1:0] DS_NONE    = 2'd0;
    localparam logic [1:0] DS_TO_AP   = 2'd1;
    localparam logic [1:0] DS_FROM_AP = 2'd2;
    localparam logic [1:0] DS_WDS     = 2'd3;

    // verdict codes
    localparam verdict_t VERDICT_OK      = 3'd0;
    localparam verdict_t VERDICT_SHORT   = 3'd1;
    localparam verdict_t VERDICT_CONTROL = 3'd2;
    localparam verdict_t VERDICT_LLC     = 3'd3;
    localparam verdict_t VERDICT_FOREIGN = 3'd4;
    localparam verdict_t VERDICT_STA_BSS = 3'd5;
    localparam verdict_t VERDICT_GROUP   = 3'd6;
    localparam verdict_t VERDICT_WDS     = 3'd7;

    // record queue between parser and judge
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // one classified frame header
    typedef struct packed {
        verdict_t   early;
        logic [1:0] ds;
        mac_t       bssid;
        mac_t       station;
        port_t      port;
    } frame_rec_t;

endpackage

`default_nettype wire

FILE: src/wifi_frame_station_filter.sv
// wifi_frame_station_filter: 802.11 header station filter, one frame byte per cycle.
// Takes one byte every cycle while full is low; full rises only when four records wait behind an unread verdict.
// A verdict reaches the result ports through the record queue register and the judge result register;
// verdicts leave one per cycle while pop is held high.
// Reset clears the frame state, the port mac registers (to zero), the record queue and the result valid flag.
// depends on wfsf_pkg, wfsf_parse, wfsf_fifo, wfsf_judge
`default_nettype none

module wifi_frame_station_filter #(
    parameter int PORT_COUNT = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [7:0]                         frame_byte,
    input  wire logic                               last_byte,
    input  wire logic [wfsf_pkg::PORT_W-1:0]        port,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic                                    accepted,
    output logic [wfsf_pkg::VERDICT_W-1:0]          verdict,
    output logic [wfsf_pkg::MAC_W-1:0]              station_addr,
    output logic [wfsf_pkg::MAC_W-1:0]              bssid_addr,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [wfsf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [wfsf_pkg::MAC_W-1:0]         cfg_data
);

    wfsf_pkg::mac_t       port_mac_reg [PORT_COUNT];
    logic                 take;
    logic                 rec_push;
    wfsf_pkg::frame_rec_t rec_in;
    wfsf_pkg::frame_rec_t rec_out;
    logic                 rec_ready;
    logic                 rec_take;
    logic                 q_full;

    // port mac registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
                port_mac_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                if (cfg_index == wfsf_pkg::CFG_INDEX_W'(i))
                    port_mac_reg[i] <= cfg_data;
            end
        end
    end

    // input request handshake
    assign full = q_full;
    assign take = push && !q_full;

    wfsf_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .port       (port),
        .rec_push   (rec_push),
        .rec        (rec_in)
    );

    wfsf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (rec_push),
        .wr_data   (rec_in),
        .full      (q_full),
        .rd_en     (rec_take),
        .rd_data   (rec_out),
        .not_empty (rec_ready)
    );

    wfsf_judge #(
        .PORT_COUNT (PORT_COUNT)
    ) u_judge (
        .clk          (clk),
        .rst_n        (rst_n),
        .port_mac     (port_mac_reg),
        .rec_ready    (rec_ready),
        .rec          (rec_out),
        .rec_take     (rec_take),
        .empty        (empty),
        .pop          (pop),
        .accepted     (accepted),
        .verdict      (verdict),
        .station_addr (station_addr),
        .bssid_addr   (bssid_addr)
    );

endmodule

`default_nettype wire

FILE: src/wfsf_parse.sv
// wfsf_parse: front end, collects header bytes and classifies each frame on its last byte
// depends on wfsf_pkg
`default_nettype none

module wfsf_parse (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic [7:0]          frame_byte,
    input  wire logic                last_byte,
    input  wire wfsf_pkg::port_t     port,
    output logic                     rec_push,
    output wfsf_pkg::frame_rec_t     rec
);

    wfsf_pkg::count_t count_reg, count_next;
    logic [7:0]       fc_lo_reg, fc_lo_next;
    logic [7:0]       fc_hi_reg, fc_hi_next;
    wfsf_pkg::mac_t   addr1_reg, addr1_next;
    wfsf_pkg::mac_t   addr2_reg, addr2_next;
    wfsf_pkg::mac_t   addr3_reg, addr3_next;
    logic             llc_zero_reg, llc_zero_next;
    logic [1:0]       ds;

    // header field capture, values after this byte
    always_comb
    begin
        fc_lo_next    = fc_lo_reg;
        fc_hi_next    = fc_hi_reg;
        addr1_next    = addr1_reg;
        addr2_next    = addr2_reg;
        addr3_next    = addr3_reg;
        llc_zero_next = llc_zero_reg;
        if (count_reg == 5'd0)
        begin
            fc_lo_next = frame_byte;
        end
        else if (count_reg == 5'd1)
        begin
            fc_hi_next = frame_byte;
        end
        else if (count_reg inside {[5'd4:5'd9]})
        begin
            addr1_next = {addr1_reg[wfsf_pkg::MAC_W-9:0], frame_byte};
        end
        else if (count_reg inside {[5'd10:5'd15]})
        begin
            addr2_next = {addr2_reg[wfsf_pkg::MAC_W-9:0], frame_byte};
        end
        else if (count_reg inside {[5'd16:5'd21]})
        begin
            addr3_next = {addr3_reg[wfsf_pkg::MAC_W-9:0], frame_byte};
        end
        else if (count_reg inside {[5'd24:5'd27]} && frame_byte != 8'd0)
        begin
            llc_zero_next = 1'b0;
        end
        count_next = (count_reg < wfsf_pkg::COUNT_MAX) ? count_reg + 5'd1 : count_reg;
    end

    // classification of the finished header
    assign ds = fc_hi_next[1:0];

    always_comb
    begin
        rec.port = port;
        rec.ds   = ds;
        if (count_next < wfsf_pkg::HDR_LEN)
            rec.early = wfsf_pkg::VERDICT_SHORT;
        else if ((fc_lo_next & wfsf_pkg::FC_TYPE_MASK) == wfsf_pkg::FC_TYPE_CTRL)
            rec.early = wfsf_pkg::VERDICT_CONTROL;
        else if (count_next > wfsf_pkg::LLC_END && llc_zero_next)
            rec.early = wfsf_pkg::VERDICT_LLC;
        else
            rec.early = wfsf_pkg::VERDICT_OK;
        case (ds)
            wfsf_pkg::DS_NONE:
            begin
                rec.bssid   = addr3_next;
                rec.station = addr2_next;
            end
            wfsf_pkg::DS_TO_AP:
            begin
                rec.bssid   = addr1_next;
                rec.station = addr2_next;
            end
            default:
            begin
                rec.bssid   = addr2_next;
                rec.station = addr1_next;
            end
        endcase
    end

    assign rec_push = take && last_byte;

    // frame state, back to reset after each last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            fc_lo_reg    <= '0;
            fc_hi_reg    <= '0;
            addr1_reg    <= '0;
            addr2_reg    <= '0;
            addr3_reg    <= '0;
            llc_zero_reg <= 1'b1;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                count_reg    <= '0;
                fc_lo_reg    <= '0;
                fc_hi_reg    <= '0;
                addr1_reg    <= '0;
                addr2_reg    <= '0;
                addr3_reg    <= '0;
                llc_zero_reg <= 1'b1;
            end
            else
            begin
                count_reg    <= count_next;
                fc_lo_reg    <= fc_lo_next;
                fc_hi_reg    <= fc_hi_next;
                addr1_reg    <= addr1_next;
                addr2_reg    <= addr2_next;
                addr3_reg    <= addr3_next;
                llc_zero_reg <= llc_zero_next;
            end
        end
    end

    // a frame always starts from a cleared count
    a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |=> (count_reg == 5'd0 && llc_zero_reg))
        else $error("frame state not cleared after last byte");

endmodule

`default_nettype wire

FILE: src/wfsf_fifo.sv
// wfsf_fifo: short record queue between parser and judge
// depends on wfsf_pkg
`default_nettype none

module wfsf_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire wfsf_pkg::frame_rec_t wr_data,
    output logic                      full,
    input  wire logic                 rd_en,
    output wfsf_pkg::frame_rec_t      rd_data,
    output logic                      not_empty
);

    wfsf_pkg::frame_rec_t            slot_reg [wfsf_pkg::QUEUE_DEPTH];
    logic [wfsf_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [wfsf_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [wfsf_pkg::QCNT_W-1:0]     count_reg;
    logic [wfsf_pkg::QCNT_W-1:0]     count_next;

    assign full      = (count_reg == wfsf_pkg::QCNT_W'(wfsf_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("record queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && !not_empty))
        else $error("record queue read while empty");

endmodule

`default_nettype wire

FILE: src/wfsf_judge.sv
// wfsf_judge: back end, checks bssid against the port mac, passes on the station of an accepted frame, holds the result
// depends on wfsf_pkg
`default_nettype none

module wfsf_judge #(
    parameter int PORT_COUNT = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire wfsf_pkg::mac_t       port_mac [PORT_COUNT],
    input  wire logic                 rec_ready,
    input  wire wfsf_pkg::frame_rec_t rec,
    output logic                      rec_take,
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      accepted,
    output wfsf_pkg::verdict_t        verdict,
    output wfsf_pkg::mac_t            station_addr,
    output wfsf_pkg::mac_t            bssid_addr
);

    logic               out_valid_reg;
    logic               accepted_reg;
    wfsf_pkg::verdict_t verdict_reg;
    wfsf_pkg::mac_t     station_reg;
    wfsf_pkg::mac_t     bssid_reg;
    wfsf_pkg::mac_t     own_mac;
    logic               port_hit;
    wfsf_pkg::verdict_t verdict_next;

    // port mac select; ports beyond the configured count never hit
    always_comb
    begin
        own_mac  = '0;
        port_hit = 1'b0;
        for (int i = 0; i < PORT_COUNT; i++)
        begin
            if (rec.port == wfsf_pkg::PORT_W'(i))
            begin
                own_mac  = port_mac[i];
                port_hit = 1'b1;
            end
        end
    end

    // verdict in check order
    always_comb
    begin
        if (rec.early != wfsf_pkg::VERDICT_OK)
            verdict_next = rec.early;
        else if (!port_hit || rec.bssid != own_mac)
            verdict_next = wfsf_pkg::VERDICT_FOREIGN;
        else if (rec.ds == wfsf_pkg::DS_NONE && rec.station == rec.bssid)
            verdict_next = wfsf_pkg::VERDICT_STA_BSS;
        else if (rec.ds == wfsf_pkg::DS_FROM_AP && rec.station[wfsf_pkg::GROUP_BIT])
            verdict_next = wfsf_pkg::VERDICT_GROUP;
        else if (rec.ds == wfsf_pkg::DS_WDS)
            verdict_next = wfsf_pkg::VERDICT_WDS;
        else
            verdict_next = wfsf_pkg::VERDICT_OK;
    end

    // take a record whenever the output slot is free or being drained
    assign rec_take = rec_ready && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rec_take)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            accepted_reg <= (verdict_next == wfsf_pkg::VERDICT_OK);
            verdict_reg  <= verdict_next;
            station_reg  <= (verdict_next == wfsf_pkg::VERDICT_OK) ? rec.station : '0;
            bssid_reg    <= (verdict_next == wfsf_pkg::VERDICT_OK) ? rec.bssid : '0;
        end
    end

    assign empty        = !out_valid_reg;
    assign accepted     = accepted_reg;
    assign verdict      = verdict_reg;
    assign station_addr = station_reg;
    assign bssid_addr   = bssid_reg;

    a_reject_clears_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !accepted_reg) |-> (station_reg == '0 && bssid_reg == '0))
        else $error("rejected frame shows addresses");

endmodule

`default_nettype wire

FILE: verif/wifi_frame_station_filter_checker.sv
`timescale 1ns / 100ps
// wifi_frame_station_filter_checker: watches the byte, verdict and register channels
// of the station filter, predicts every verdict and compares it field by field
// depends on wfsf_pkg
module wifi_frame_station_filter_checker #(
    parameter int PORT_COUNT = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             full,
    input  logic [7:0]                       frame_byte,
    input  logic                             last_byte,
    input  wfsf_pkg::port_t                  port,
    input  logic                             empty,
    input  logic                             pop,
    input  logic                             accepted,
    input  wfsf_pkg::verdict_t               verdict,
    input  wfsf_pkg::mac_t                   station_addr,
    input  wfsf_pkg::mac_t                   bssid_addr,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [wfsf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wfsf_pkg::mac_t                   cfg_data,
    output int                               mismatch_count,
    output int                               verdicts_owed
);

    localparam int MAC_REGS = 8;

    typedef struct packed {
        logic               ok;
        wfsf_pkg::verdict_t code;
        wfsf_pkg::mac_t     sta;
        wfsf_pkg::mac_t     bss;
    } frame_verdict_t;

    // predicted copy of the register file and the header capture
    wfsf_pkg::mac_t   own_mac [MAC_REGS];
    wfsf_pkg::count_t seen_cnt;
    logic [7:0]       fc_lo;
    logic [7:0]       fc_hi;
    wfsf_pkg::mac_t   addr1;
    wfsf_pkg::mac_t   addr2;
    wfsf_pkg::mac_t   addr3;
    logic             llc_zero;
    frame_verdict_t   verdict_q [$];
    int               errs;

    task automatic clear_frame();
        seen_cnt = '0;
        fc_lo    = '0;
        fc_hi    = '0;
        addr1    = '0;
        addr2    = '0;
        addr3    = '0;
        llc_zero = 1'b1;
    endtask

    // capture one header byte by its position in the frame
    task automatic capture_byte(input logic [7:0] b);
        if (seen_cnt == 0)
            fc_lo = b;
        else if (seen_cnt == 1)
            fc_hi = b;
        else if (seen_cnt >= 4 && seen_cnt <= 9)
            addr1 = {addr1[wfsf_pkg::MAC_W-9:0], b};
        else if (seen_cnt >= 10 && seen_cnt <= 15)
            addr2 = {addr2[wfsf_pkg::MAC_W-9:0], b};
        else if (seen_cnt >= 16 && seen_cnt <= 21)
            addr3 = {addr3[wfsf_pkg::MAC_W-9:0], b};
        else if (seen_cnt >= wfsf_pkg::HDR_LEN && seen_cnt < wfsf_pkg::LLC_END
                 && b != 8'h00)
            llc_zero = 1'b0;
        if (seen_cnt < wfsf_pkg::COUNT_MAX)
            seen_cnt = seen_cnt + 1'b1;
    endtask

    // verdict for the frame just closed, checks in priority order
    function automatic frame_verdict_t judge_frame(input wfsf_pkg::port_t p);
        frame_verdict_t r;
        logic [1:0]     ds;
        wfsf_pkg::mac_t bss;
        r    = '0;
        ds   = fc_hi[1:0];
        bss  = '0;
        if (seen_cnt < wfsf_pkg::HDR_LEN)
            r.code = wfsf_pkg::VERDICT_SHORT;
        else if ((fc_lo & wfsf_pkg::FC_TYPE_MASK) == wfsf_pkg::FC_TYPE_CTRL)
            r.code = wfsf_pkg::VERDICT_CONTROL;
        else if (seen_cnt > wfsf_pkg::LLC_END && llc_zero)
            r.code = wfsf_pkg::VERDICT_LLC;
        else
        begin
            case (ds)
                wfsf_pkg::DS_NONE:  bss = addr3;
                wfsf_pkg::DS_TO_AP: bss = addr1;
                default:            bss = addr2;
            endcase
            if (int'(p) >= PORT_COUNT || bss != own_mac[p])
                r.code = wfsf_pkg::VERDICT_FOREIGN;
            else
            begin
                case (ds)
                    wfsf_pkg::DS_NONE:
                        if (addr2 == bss)
                            r.code = wfsf_pkg::VERDICT_STA_BSS;
                        else
                            r.sta = addr2;
                    wfsf_pkg::DS_TO_AP:
                        r.sta = addr2;
                    wfsf_pkg::DS_FROM_AP:
                        if (addr1[wfsf_pkg::GROUP_BIT])
                            r.code = wfsf_pkg::VERDICT_GROUP;
                        else
                            r.sta = addr1;
                    default:
                        r.code = wfsf_pkg::VERDICT_WDS;
                endcase
                if (r.code == wfsf_pkg::VERDICT_OK)
                    r.bss = bss;
            end
        end
        r.ok = (r.code == wfsf_pkg::VERDICT_OK);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [wfsf_pkg::MAC_W-1:0] want,
                               input logic [wfsf_pkg::MAC_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errs = errs + 1;
        end
    endtask

    // sample every channel at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_verdict_t want;
        if (!rst_n)
        begin
            clear_frame();
            for (int i = 0; i < MAC_REGS; i++)
                own_mac[i] = '0;
            verdict_q.delete();
            errs = 0;
            mismatch_count <= 0;
            verdicts_owed  <= 0;
        end
        else
        begin
            // register write request
            if (cfg_valid && cfg_ready && int'(cfg_index) < MAC_REGS)
                own_mac[cfg_index] = cfg_data;

            // verdict request leaving the block
            if (pop && !empty)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected verdict, expected none, actual verdict %0d",
                             $time, verdict);
                    errs = errs + 1;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("accepted", wfsf_pkg::MAC_W'(want.ok),
                                wfsf_pkg::MAC_W'(accepted));
                    check_field("verdict", wfsf_pkg::MAC_W'(want.code),
                                wfsf_pkg::MAC_W'(verdict));
                    check_field("station_addr", want.sta, station_addr);
                    check_field("bssid_addr", want.bss, bssid_addr);
                end
            end

            // byte request entering the block
            if (push && !full)
            begin
                capture_byte(frame_byte);
                if (last_byte)
                begin
                    verdict_q.push_back(judge_frame(port));
                    clear_frame();
                end
            end

            mismatch_count <= errs;
            verdicts_owed  <= verdict_q.size();
        end
    end

endmodule

FILE: verif/wifi_frame_station_filter_tb.sv
`timescale 1ns / 100ps
// wifi_frame_station_filter_tb: drives frames and register writes into the station filter
// and gives the final verdict; checking lives in wifi_frame_station_filter_checker
// depends on wfsf_pkg, wifi_frame_station_filter, wifi_frame_station_filter_checker
module wifi_frame_station_filter_tb;

    localparam int MAC_REGS       = 8;
    localparam int REG_PORT_MAC_0 = 0;
    localparam int STARVE_CYCLES  = 300;
    localparam int BYTE_TARGET    = 1400;

    logic                             clk;
    logic                             rst_n;
    logic                             push;
    logic                             full;
    logic [7:0]                       frame_byte;
    logic                             last_byte;
    wfsf_pkg::port_t                  port;
    logic                             empty;
    logic                             pop;
    logic                             accepted;
    wfsf_pkg::verdict_t               verdict;
    wfsf_pkg::mac_t                   station_addr;
    wfsf_pkg::mac_t                   bssid_addr;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [wfsf_pkg::CFG_INDEX_W-1:0] cfg_index;
    wfsf_pkg::mac_t                   cfg_data;
    int                               mismatch_count;
    int                               verdicts_owed;

    wfsf_pkg::mac_t mac_plan [MAC_REGS];
    logic [7:0]     frame_buf [$];
    int             bytes_sent = 0;
    int             gap_rate   = 0;
    bit             gaps_on    = 1'b1;
    bit             starve_req = 1'b0;

    wifi_frame_station_filter #(.PORT_COUNT(8)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte),
        .port         (port),
        .empty        (empty),
        .pop          (pop),
        .accepted     (accepted),
        .verdict      (verdict),
        .station_addr (station_addr),
        .bssid_addr   (bssid_addr),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    wifi_frame_station_filter_checker #(.PORT_COUNT(8)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .frame_byte     (frame_byte),
        .last_byte      (last_byte),
        .port           (port),
        .empty          (empty),
        .pop            (pop),
        .accepted       (accepted),
        .verdict        (verdict),
        .station_addr   (station_addr),
        .bssid_addr     (bssid_addr),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .verdicts_owed  (verdicts_owed)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic wfsf_pkg::mac_t rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[wfsf_pkg::MAC_W-1:0];
    endfunction

    // one byte request, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input wfsf_pkg::port_t p);
        if (gaps_on && $urandom_range(0, 15) < gap_rate)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clk);
        end
        @(negedge clk);
        push       <= 1'b1;
        frame_byte <= b;
        last_byte  <= last;
        port       <= p;
        do @(posedge clk); while (full);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic put_mac(input wfsf_pkg::mac_t m);
        for (int i = 5; i >= 0; i--)
            frame_buf.push_back(m[i*8 +: 8]);
    endtask

    // build a frame header plus body and stream it out
    task automatic emit_frame(input logic [7:0] fcl, input logic [7:0] fch,
                              input wfsf_pkg::mac_t a1, input wfsf_pkg::mac_t a2,
                              input wfsf_pkg::mac_t a3,
                              input int len, input bit llc_null, input wfsf_pkg::port_t p,
                              input bit hop_port);
        wfsf_pkg::port_t pb;
        gap_rate = $urandom_range(0, 4);
        frame_buf.delete();
        frame_buf.push_back(fcl);
        frame_buf.push_back(fch);
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(8'($urandom));
        put_mac(a1);
        put_mac(a2);
        put_mac(a3);
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(8'($urandom));
        for (int i = 24; i < len; i++)
            frame_buf.push_back((llc_null && i < 28) ? 8'h00 : 8'($urandom));
        while (frame_buf.size() > len)
            void'(frame_buf.pop_back());
        foreach (frame_buf[i])
        begin
            pb = (hop_port && i != frame_buf.size() - 1) ? wfsf_pkg::port_t'($urandom) : p;
            send_byte(frame_buf[i], i == frame_buf.size() - 1, pb);
        end
    endtask

    // mostly well-formed headers aimed at the port's own bssid
    task automatic random_frame();
        wfsf_pkg::port_t p;
        logic [1:0]      ds;
        logic [7:0]      fcl;
        wfsf_pkg::mac_t  bss;
        wfsf_pkg::mac_t  sta;
        wfsf_pkg::mac_t  a1;
        wfsf_pkg::mac_t  a2;
        wfsf_pkg::mac_t  a3;
        int              pick;
        int              len;
        p   = wfsf_pkg::port_t'($urandom_range(0, 7));
        ds  = 2'($urandom_range(0, 3));
        fcl = 8'($urandom);
        if ($urandom_range(0, 99) < 8)
            fcl[3:2] = 2'b01;
        else if (fcl[3:2] == 2'b01)
            fcl[3:2] = 2'b10;
        bss = ($urandom_range(0, 9) < 8) ? mac_plan[p] : rand_mac();
        sta = (ds == wfsf_pkg::DS_NONE && $urandom_range(0, 6) == 0) ? bss : rand_mac();
        a1  = rand_mac();
        a2  = rand_mac();
        a3  = rand_mac();
        case (ds)
            wfsf_pkg::DS_NONE:
            begin
                a2 = sta;
                a3 = bss;
            end
            wfsf_pkg::DS_TO_AP:
            begin
                a1 = bss;
                a2 = sta;
            end
            wfsf_pkg::DS_FROM_AP:
            begin
                a1 = sta;
                a2 = bss;
            end
            default:
                a2 = bss;
        endcase
        pick = $urandom_range(0, 9);
        if (pick == 0)
            len = $urandom_range(1, 23);
        else if (pick == 1)
            len = $urandom_range(24, 28);
        else if (pick == 2)
            len = $urandom_range(41, 64);
        else
            len = $urandom_range(29, 40);
        emit_frame(fcl, {6'($urandom), ds}, a1, a2, a3, len,
                   $urandom_range(0, 6) == 0, p, $urandom_range(0, 9) == 0);
    endtask

    task automatic run_random(input int upto);
        while (bytes_sent < upto)
            random_frame();
    endtask

    // write every port mac register from the plan
    task automatic load_port_macs();
        for (int i = 0; i < MAC_REGS; i++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= wfsf_pkg::CFG_INDEX_W'(REG_PORT_MAC_0 + i);
            cfg_data  <= mac_plan[i];
            do @(posedge clk); while (!cfg_ready);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold the sender until every predicted verdict has been taken
    task automatic wait_results_drained();
        @(negedge clk);
        push <= 1'b0;
        repeat (4) @(posedge clk);
        while (verdicts_owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin : result_drain
        int stall_left;
        int stall_rate;
        stall_left = 0;
        stall_rate = 2;
        forever
        begin
            @(negedge clk);
            if (starve_req)
            begin
                pop <= 1'b0;
                repeat (STARVE_CYCLES - 1) @(negedge clk);
                starve_req = 1'b0;
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (gaps_on && $urandom_range(0, 15) < stall_rate)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(0, 13);
            end
            else
            begin
                pop <= 1'b1;
                if ($urandom_range(0, 31) == 0)
                    stall_rate = $urandom_range(0, 4);
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        wfsf_pkg::mac_t sta;
        rst_n      = 1'b0;
        push       = 1'b0;
        frame_byte = '0;
        last_byte  = 1'b0;
        port       = '0;
        pop        = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // random macs, all-zero on port 0 and all-ones on port 7
        foreach (mac_plan[i])
            mac_plan[i] = rand_mac();
        mac_plan[0] = '0;
        mac_plan[7] = '1;
        load_port_macs();

        // directed frames, one per verdict and boundary
        sta = 48'h02_12_34_56_78_9A;
        emit_frame(8'hFF, 8'h00, sta, sta, sta, 1, 1'b0, 3'd7, 1'b0);
        emit_frame(8'h08, 8'h00, sta, sta, mac_plan[3], 23, 1'b0, 3'd3, 1'b0);
        emit_frame(8'h00, 8'h00, sta, sta, mac_plan[0], 24, 1'b0, 3'd0, 1'b0);
        emit_frame(8'hD4, 8'h00, sta, sta, mac_plan[3], 24, 1'b0, 3'd3, 1'b0);
        emit_frame(8'h08, 8'h00, sta, sta, mac_plan[3], 29, 1'b1, 3'd3, 1'b0);
        emit_frame(8'h08, 8'h00, sta, sta, mac_plan[3], 64, 1'b1, 3'd3, 1'b0);
        emit_frame(8'hF8, 8'hFD, mac_plan[7], '1, '1, 28, 1'b1, 3'd7, 1'b0);
        emit_frame(8'h08, 8'h00, sta, sta, ~mac_plan[3], 30, 1'b0, 3'd3, 1'b0);
        emit_frame(8'h08, 8'h00, sta, mac_plan[3], mac_plan[3], 30, 1'b0, 3'd3, 1'b0);
        emit_frame(8'h08, 8'h02, 48'h01_00_5E_00_00_01, mac_plan[3], sta, 30, 1'b0,
                   3'd3, 1'b0);
        emit_frame(8'h08, 8'h02, sta, mac_plan[3], sta, 40, 1'b0, 3'd3, 1'b0);
        emit_frame(8'h08, 8'h03, sta, mac_plan[3], sta, 30, 1'b0, 3'd3, 1'b0);
        emit_frame(8'h08, 8'h01, mac_plan[5], sta, sta, 32, 1'b0, 3'd5, 1'b1);
        run_random(BYTE_TARGET / 4);
        wait_results_drained();

        // all-ones macs, with a long hold on the verdict side
        starve_req = 1'b1;
        foreach (mac_plan[i])
            mac_plan[i] = '1;
        load_port_macs();
        gaps_on = 1'b0;
        repeat (24)
            emit_frame(8'($urandom), 8'($urandom), sta, sta, sta, 1, 1'b0,
                       wfsf_pkg::port_t'($urandom), 1'b0);
        gaps_on = 1'b1;
        run_random(BYTE_TARGET / 2);
        wait_results_drained();

        // all-zero macs
        foreach (mac_plan[i])
            mac_plan[i] = '0;
        load_port_macs();
        run_random(3 * BYTE_TARGET / 4);
        wait_results_drained();

        // mixed macs, no idling on either side
        gaps_on = 1'b0;
        foreach (mac_plan[i])
            mac_plan[i] = rand_mac();
        mac_plan[2] = '1;
        mac_plan[6] = '0;
        load_port_macs();
        run_random(BYTE_TARGET);
        @(negedge clk);
        push <= 1'b0;
        wait_results_drained();

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
